>>> rtl/idls_pkg.sv
// Package for the indentation line scanner: byte codes, command and status types.
// No dependencies; compiled first.
`default_nettype none
package idls_pkg;

  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_NUL   = 8'd0;

  localparam int unsigned DEDENT_W = 5;
  localparam int unsigned WIDTH_W  = 8;
  localparam int unsigned LINENO_W = 16;

  // controller -> datapath
  typedef struct packed {
    logic take_beat;  // input beat accepted this cycle
    logic cmp;        // compare line width with top of stack, push or pop
    logic load_top;   // reload top register from stack RAM after a pop
    logic emit;       // load the output register
  } idls_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic close_nonblank;  // beat on input closes a non-blank line
    logic shallower;       // line width below the current top
    logic out_free;        // output register can take a result
  } idls_sts_t;

endpackage
`default_nettype wire

>>> rtl/idls_if.sv
// Valid/ready channel interfaces for the scanner's byte input and line results.
// Depends on nothing.
`default_nettype none
interface idls_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_stream;

  modport source (output valid, output ch, output end_of_stream, input ready);
  modport sink   (input valid, input ch, input end_of_stream, output ready);
endinterface

interface idls_out_if;
  logic        valid;
  logic        ready;
  logic        indent_flag;
  logic [4:0]  dedent_count;
  logic [7:0]  indent_width;
  logic [15:0] line_number;
  logic        stack_overflow;

  modport source (output valid, output indent_flag, output dedent_count,
                  output indent_width, output line_number, output stack_overflow,
                  input ready);
  modport sink   (input valid, input indent_flag, input dedent_count,
                  input indent_width, input line_number, input stack_overflow,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/idls_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module idls_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

>>> rtl/idls_ctrl.sv
// Sequencer for the scanner: takes beats, then steps compare / pop / emit per line.
// Depends on idls_pkg.
`default_nettype none
module idls_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire idls_pkg::idls_sts_t sts_i,
  output idls_pkg::idls_cmd_t      cmd_o
);
  import idls_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_POP  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.take_beat = in_valid_i;
        if (in_valid_i && sts_i.close_nonblank) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = sts_i.shallower ? ST_POP : ST_OUT;
      end
      ST_POP: begin
        cmd_o.load_top = 1'b1;
        state_d        = ST_CMP;
      end
      ST_OUT: begin
        // hold until the previous result has gone
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/idls_dp.sv
// Datapath: line tracking, level stack (RAM plus top register), output register.
// Depends on idls_pkg and idls_ram.
`default_nettype none
module idls_dp #(
  parameter int unsigned STACK_DEPTH = 32,
  parameter int unsigned INDENT_BITS = 8,
  parameter int unsigned LINE_BITS   = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire idls_pkg::idls_cmd_t cmd_i,
  output idls_pkg::idls_sts_t      sts_o,
  input  wire logic [7:0]          ch_i,
  input  wire logic                end_of_stream_i,
  input  wire logic                out_ready_i,
  output logic                     out_valid_o,
  output logic                     indent_flag_o,
  output logic [4:0]               dedent_count_o,
  output logic [7:0]               indent_width_o,
  output logic [15:0]              line_number_o,
  output logic                     stack_overflow_o
);
  import idls_pkg::*;

  localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);

  // line state
  logic [INDENT_BITS-1:0] lead_q, lead_d;
  logic                   in_leading_q, in_leading_d;
  logic                   nonblank_q, nonblank_d;
  logic                   nul_seen_q, nul_seen_d;
  logic                   line_open_q, line_open_d;
  logic [LINE_BITS-1:0]   line_cnt_q, line_cnt_d;

  // per-line working registers
  logic [INDENT_BITS-1:0] w_q, w_d;
  logic                   ind_q, ind_d;
  logic                   ovf_q, ovf_d;
  logic [DEDENT_W-1:0]    pops_q, pops_d;

  // stack
  logic [CNT_W-1:0]       count_q, count_d;
  logic [INDENT_BITS-1:0] top_q, top_d;
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [INDENT_BITS-1:0] ram_rdata;
  logic [CNT_W-1:0]       below_top;

  // output register
  logic                   out_valid_q, out_valid_d;
  logic                   o_ind_q, o_ovf_q;
  logic [DEDENT_W-1:0]    o_pops_q;
  logic [INDENT_BITS-1:0] o_w_q;
  logic [LINE_BITS-1:0]   o_line_q;

  logic                   closing;
  logic                   deeper;
  logic                   shallower;
  logic                   full;

  logic [INDENT_BITS+WIDTH_W-1:0] w_ext;
  logic [LINE_BITS+LINENO_W-1:0]  line_ext;

  assign closing   = end_of_stream_i ? line_open_q : (ch_i == CH_NL);
  // no push once levels have been popped for this line
  assign deeper    = (w_q > top_q) && (pops_q == '0);
  assign shallower = (w_q < top_q);
  assign full      = (count_q == CNT_W'(STACK_DEPTH));

  assign below_top = CNT_W'(count_q - CNT_W'(2));
  assign ram_raddr = below_top[ADDR_W-1:0];
  assign ram_we    = cmd_i.cmp && deeper && !full;

  assign sts_o.close_nonblank = closing && nonblank_q;
  assign sts_o.shallower      = shallower;
  assign sts_o.out_free       = !out_valid_q || out_ready_i;

  idls_ram #(
    .WIDTH (INDENT_BITS),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[ADDR_W-1:0]),
    .wdata_i (w_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    lead_d       = lead_q;
    in_leading_d = in_leading_q;
    nonblank_d   = nonblank_q;
    nul_seen_d   = nul_seen_q;
    line_open_d  = line_open_q;
    line_cnt_d   = line_cnt_q;
    w_d          = w_q;
    ind_d        = ind_q;
    ovf_d        = ovf_q;
    pops_d       = pops_q;
    count_d      = count_q;
    top_d        = top_q;

    if (cmd_i.take_beat) begin
      if (closing) begin
        if (line_cnt_q != '1) begin
          line_cnt_d = line_cnt_q + LINE_BITS'(1);
        end
        w_d          = lead_q;
        ind_d        = 1'b0;
        ovf_d        = 1'b0;
        pops_d       = '0;
        lead_d       = '0;
        in_leading_d = 1'b1;
        nonblank_d   = 1'b0;
        nul_seen_d   = 1'b0;
        line_open_d  = 1'b0;
      end else if (!end_of_stream_i) begin
        line_open_d = 1'b1;
        if (!nul_seen_q) begin
          if (ch_i == CH_NUL) begin
            nul_seen_d = 1'b1;
          end else if (ch_i != CH_SPACE && ch_i != CH_TAB) begin
            nonblank_d = 1'b1;
          end
        end
        if (in_leading_q) begin
          if (ch_i == CH_SPACE) begin
            if (lead_q != '1) begin
              lead_d = lead_q + INDENT_BITS'(1);
            end
          end else begin
            in_leading_d = 1'b0;
          end
        end
      end
    end

    if (cmd_i.cmp) begin
      if (deeper) begin
        ind_d = 1'b1;
        if (full) begin
          ovf_d = 1'b1;
        end else begin
          count_d = count_q + CNT_W'(1);
          top_d   = w_q;
        end
      end else if (shallower) begin
        count_d = count_q - CNT_W'(1);
        if (pops_q != '1) begin
          pops_d = pops_q + DEDENT_W'(1);
        end
      end
    end

    if (cmd_i.load_top) begin
      // entry zero is never written and always reads as level 0
      top_d = (count_q == CNT_W'(1)) ? '0 : ram_rdata;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q       <= '0;
      in_leading_q <= 1'b1;
      nonblank_q   <= 1'b0;
      nul_seen_q   <= 1'b0;
      line_open_q  <= 1'b0;
      line_cnt_q   <= '0;
      count_q      <= CNT_W'(1);
      top_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      lead_q       <= lead_d;
      in_leading_q <= in_leading_d;
      nonblank_q   <= nonblank_d;
      nul_seen_q   <= nul_seen_d;
      line_open_q  <= line_open_d;
      line_cnt_q   <= line_cnt_d;
      count_q      <= count_d;
      top_q        <= top_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q    <= w_d;
    ind_q  <= ind_d;
    ovf_q  <= ovf_d;
    pops_q <= pops_d;
    if (cmd_i.emit) begin
      o_ind_q  <= ind_q;
      o_ovf_q  <= ovf_q;
      o_pops_q <= pops_q;
      o_w_q    <= w_q;
      o_line_q <= line_cnt_q;
    end
  end

  // fit parameterised widths to the fixed result fields
  assign w_ext    = {{WIDTH_W{1'b0}}, o_w_q};
  assign line_ext = {{LINENO_W{1'b0}}, o_line_q};

  assign out_valid_o      = out_valid_q;
  assign indent_flag_o    = o_ind_q;
  assign stack_overflow_o = o_ovf_q;
  assign dedent_count_o   = o_pops_q;
  assign indent_width_o   = w_ext[WIDTH_W-1:0];
  assign line_number_o    = line_ext[LINENO_W-1:0];

endmodule
`default_nettype wire

>>> rtl/indent_dedent_line_scanner.sv
// Indentation scanner: one source byte per beat, one result per non-blank line.
// Non-closing beats are taken every cycle while the sequencer is idle. A beat
// that closes a non-blank line holds the input while its width is compared with
// the top of stack, each popped level is reloaded with one RAM read, and the
// output register drains; the result is then loaded into the output register.
// Reset (async, active low) leaves the level stack at {0} and the line count
// at zero; no clearing pass is needed, entry zero of the stack is implicit.
// Depends on idls_pkg, idls_if, idls_ram, idls_ctrl and idls_dp.
`default_nettype none
module indent_dedent_line_scanner #(
  parameter int unsigned STACK_DEPTH = 32,
  parameter int unsigned INDENT_BITS = 8,
  parameter int unsigned LINE_BITS   = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  idls_in_if.sink     in_i,
  idls_out_if.source  out_o
);
  import idls_pkg::*;

  idls_cmd_t cmd;
  idls_sts_t sts;
  logic      in_ready;

  assign in_i.ready = in_ready;

  idls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  idls_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .INDENT_BITS (INDENT_BITS),
    .LINE_BITS   (LINE_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .ch_i             (in_i.ch),
    .end_of_stream_i  (in_i.end_of_stream),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .indent_flag_o    (out_o.indent_flag),
    .dedent_count_o   (out_o.dedent_count),
    .indent_width_o   (out_o.indent_width),
    .line_number_o    (out_o.line_number),
    .stack_overflow_o (out_o.stack_overflow)
  );

endmodule
`default_nettype wire
